FILE: rtl/acf_pkg.sv
// ----------------------------------------------------------------------------
// Airspeed complementary filter package
// Shared widths, reset values, limits and the interface types between the
// register file, the sequencer and the digit-serial multiplier.
// ----------------------------------------------------------------------------
package acf_pkg;

  localparam int MC_W   = 49;           // multiplicand width (signed)
  localparam int MP_W   = 17;           // multiplier width (unsigned)
  localparam int PROD_W = MC_W + MP_W;  // product width (signed)

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int IDX_W  = ADDR_W - 2;

  localparam logic [IDX_W-1:0] REG_FREQ   = 2'd0;
  localparam logic [IDX_W-1:0] REG_CRUISE = 2'd1;
  localparam logic [IDX_W-1:0] REG_SENSOR = 2'd2;

  localparam logic [15:0] FREQ_RESET   = 16'd8192;
  localparam logic [17:0] CRUISE_RESET = 18'd15360;
  localparam logic        SENSOR_RESET = 1'b1;

  localparam logic [16:0] DT_LOW    = 17'd66;
  localparam logic [16:0] DT_HIGH   = 17'd65536;
  localparam logic [16:0] SQRT2_Q14 = 17'd23170;

  localparam logic signed [31:0] SPEED_FLOOR  = 32'sd196608;
  localparam logic signed [31:0] WINDUP_LIMIT = 32'sd203162;

  typedef struct packed {
    logic [15:0] filter_frequency;
    logic [17:0] cruise_airspeed;
    logic        sensor_enabled;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [MC_W-1:0]   mcand;
    logic [MP_W-1:0]   mplier;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

endpackage

FILE: rtl/acf_mul.sv
// ----------------------------------------------------------------------------
// Digit-serial multiplier
// Signed multiplicand times unsigned multiplier, one multiplier digit per
// cycle, full-width product held until the next start.
// ----------------------------------------------------------------------------
module acf_mul import acf_pkg::*; #(
  parameter int DIGIT_W = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int NDIG  = (MP_W + DIGIT_W - 1) / DIGIT_W;
  localparam int MPR_W = NDIG * DIGIT_W;
  localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

  logic                     busy;
  logic                     done;
  logic [CNT_W-1:0]         cnt;
  logic signed [PROD_W-1:0] mc_sh;
  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] partial;
  logic [MPR_W-1:0]         mp;

  assign partial = mc_sh * $signed({1'b0, mp[DIGIT_W-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NDIG - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      mc_sh <= PROD_W'($signed(req.mcand));
      mp    <= MPR_W'(req.mplier);
      acc   <= '0;
    end else if (busy) begin
      acc   <= acc + partial;
      mc_sh <= mc_sh <<< DIGIT_W;
      mp    <= mp >> DIGIT_W;
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("multiplier done without a preceding run");

endmodule

FILE: rtl/acf_regs.sv
// ----------------------------------------------------------------------------
// Configuration register file
// APB-style access to filter frequency, cruise airspeed and sensor enable.
// ----------------------------------------------------------------------------
module acf_regs import acf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [IDX_W-1:0] idx;
  logic             wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_frequency <= FREQ_RESET;
      cfg.cruise_airspeed  <= CRUISE_RESET;
      cfg.sensor_enabled   <= SENSOR_RESET;
    end else if (wr) begin
      case (idx)
        REG_FREQ:   cfg.filter_frequency <= pwdata[15:0];
        REG_CRUISE: cfg.cruise_airspeed  <= pwdata[17:0];
        REG_SENSOR: cfg.sensor_enabled   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FREQ:   prdata = DATA_W'(cfg.filter_frequency);
      REG_CRUISE: prdata = DATA_W'(cfg.cruise_airspeed);
      REG_SENSOR: prdata = DATA_W'(cfg.sensor_enabled);
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: rtl/acf_core.sv
// ----------------------------------------------------------------------------
// Filter sequencer and datapath
// Steps one sample through the chained products on the shared digit-serial
// multiplier, updates the speed and rate states and holds the result word.
// ----------------------------------------------------------------------------
module acf_core import acf_pkg::*; #(
  parameter int DIGIT_W = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [17:0]        measured_airspeed,
  input  logic               airspeed_valid,
  input  logic [15:0]        density_ratio,
  input  logic signed [17:0] raw_speed_rate,
  input  logic [16:0]        time_step,
  input  logic               in_air,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [17:0]        tas_estimate,
  output logic signed [23:0] tas_rate_estimate,
  output logic signed [18:0] innovation
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_MEAS  = 4'd2;
  localparam logic [3:0] S_INNOV = 4'd3;
  localparam logic [3:0] S_P1    = 4'd4;
  localparam logic [3:0] S_RI    = 4'd5;
  localparam logic [3:0] S_DAMP  = 4'd6;
  localparam logic [3:0] S_RATE  = 4'd7;
  localparam logic [3:0] S_SPD   = 4'd8;
  localparam logic [3:0] S_SPEED = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]               state;
  logic                     started;
  logic [17:0]              eas;
  logic [15:0]              ratio;
  logic signed [17:0]       raw;
  logic [16:0]              dt;
  logic                     reset_flag;
  logic [25:0]              meas;
  logic signed [31:0]       speed;
  logic signed [31:0]       rate;
  logic signed [32:0]       innov;
  logic [MC_W-1:0]          p1;
  logic signed [40:0]       ri;
  logic signed [37:0]       damp;

  mul_req_t                 req;
  mul_rsp_t                 rsp;
  logic signed [PROD_W-1:0] prod;

  logic                     use_meas;
  logic [16:0]              dt_clamped;
  logic signed [32:0]       innov_calc;
  logic signed [40:0]       ri_calc;
  logic signed [42:0]       rate_sum;
  logic signed [39:0]       spd_calc;
  logic signed [42:0]       speed_sum;
  logic signed [31:0]       speed_sat;

  function automatic logic [31:0] sat32(input logic [42:0] v);
    if (v[42:31] == '0 || v[42:31] == '1) begin
      return v[31:0];
    end
    return v[42] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  acf_mul #(.DIGIT_W(DIGIT_W)) u_mul (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign prod     = $signed(rsp.product);
  assign in_ready = (state == S_IDLE);
  assign use_meas = airspeed_valid & cfg.sensor_enabled;

  always_comb begin
    if (time_step < DT_LOW) begin
      dt_clamped = DT_LOW;
    end else if (time_step > DT_HIGH) begin
      dt_clamped = DT_HIGH;
    end else begin
      dt_clamped = time_step;
    end
  end

  assign innov_calc = 33'($signed({1'b0, meas})) - 33'(speed);

  always_comb begin
    ri_calc = $signed(prod[64:24]);
    if (speed < WINDUP_LIMIT && ri_calc[40]) begin
      ri_calc = '0;
    end
  end

  assign rate_sum  = 43'(rate) + 43'($signed(prod[57:16]));
  assign spd_calc  = 40'(rate) + 40'($signed({raw, 6'b0})) + 40'(damp);
  assign speed_sum = 43'(speed) + 43'($signed(prod[56:16]));

  always_comb begin
    speed_sat = $signed(sat32(speed_sum));
    if (speed_sat < SPEED_FLOOR) begin
      speed_sat = SPEED_FLOOR;
    end
  end

  always_comb begin
    req.start  = 1'b0;
    req.mcand  = '0;
    req.mplier = '0;
    case (state)
      S_LOAD: begin
        req.start  = 1'b1;
        req.mcand  = MC_W'(eas);
        req.mplier = MP_W'(ratio);
      end
      S_INNOV: begin
        req.start  = 1'b1;
        req.mcand  = MC_W'(innov_calc);
        req.mplier = MP_W'(cfg.filter_frequency);
      end
      S_P1: begin
        req.start  = rsp.done;
        req.mcand  = rsp.product[MC_W-1:0];
        req.mplier = MP_W'(cfg.filter_frequency);
      end
      S_RI: begin
        req.start  = rsp.done;
        req.mcand  = p1;
        req.mplier = SQRT2_Q14;
      end
      S_DAMP: begin
        req.start  = rsp.done;
        req.mcand  = MC_W'(ri);
        req.mplier = dt;
      end
      S_SPD: begin
        req.start  = 1'b1;
        req.mcand  = MC_W'(spd_calc);
        req.mplier = dt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      started   <= 1'b0;
      out_valid <= 1'b0;
      speed     <= '0;
      rate      <= '0;
    end else begin
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_MEAS;
        end
        S_MEAS: begin
          if (rsp.done) begin
            if (reset_flag) begin
              speed <= $signed(32'({prod[33:14], 6'b0}));
              rate  <= '0;
            end
            state <= S_INNOV;
          end
        end
        S_INNOV: begin
          state <= S_P1;
        end
        S_P1: begin
          if (rsp.done) begin
            state <= S_RI;
          end
        end
        S_RI: begin
          if (rsp.done) begin
            state <= S_DAMP;
          end
        end
        S_DAMP: begin
          if (rsp.done) begin
            state <= S_RATE;
          end
        end
        S_RATE: begin
          if (rsp.done) begin
            rate  <= $signed(sat32(rate_sum));
            state <= S_SPD;
          end
        end
        S_SPD: begin
          state <= S_SPEED;
        end
        S_SPEED: begin
          if (rsp.done) begin
            speed   <= speed_sat;
            started <= 1'b1;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      eas        <= use_meas ? measured_airspeed : cfg.cruise_airspeed;
      ratio      <= density_ratio;
      raw        <= use_meas ? raw_speed_rate : '0;
      dt         <= dt_clamped;
      reset_flag <= !started || !in_air;
    end
    if (state == S_MEAS && rsp.done) begin
      meas <= {prod[33:14], 6'b0};
    end
    if (state == S_INNOV) begin
      innov <= innov_calc;
    end
    if (state == S_P1 && rsp.done) begin
      p1 <= rsp.product[MC_W-1:0];
    end
    if (state == S_RI && rsp.done) begin
      ri <= ri_calc;
    end
    if (state == S_DAMP && rsp.done) begin
      damp <= $signed(prod[63:26]);
    end
    if (state == S_OUT && (!out_valid || out_ready)) begin
      tas_estimate <= (speed[31:24] != '0) ? 18'h3FFFF : speed[23:6];
      if (rate[31:29] == '0 || rate[31:29] == '1) begin
        tas_rate_estimate <= $signed(rate[29:6]);
      end else begin
        tas_rate_estimate <= rate[31] ? 24'sh80_0000 : 24'sh7F_FFFF;
      end
      if (innov[32:24] == '0 || innov[32:24] == '1) begin
        innovation <= $signed(innov[24:6]);
      end else begin
        innovation <= innov[32] ? 19'sh4_0000 : 19'sh3_FFFF;
      end
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_MEAS || state == S_P1 || state == S_RI ||
                  state == S_DAMP || state == S_RATE || state == S_SPEED))
    else $error("multiplier result outside a wait state");

  a_speed_floor: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> started && speed >= SPEED_FLOOR)
    else $error("speed estimate below floor at result");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!out_valid || out_ready)) |=> out_valid && state == S_IDLE)
    else $error("result word not loaded");

endmodule

FILE: rtl/airspeed_complementary_filter_top.sv
// ----------------------------------------------------------------------------
// Airspeed complementary filter top level
// Second-order complementary filter for true airspeed with APB configuration.
// ----------------------------------------------------------------------------
// One sample occupies the block while six dependent products run in turn on one
// digit-serial multiplier that retires DIGIT_W multiplier bits per cycle, over
// NDIG = ceil(17/DIGIT_W) digits. in_ready is high only between samples; a
// finished result word sits in an output register, so the next sample is taken
// while it waits. Registers: filter_frequency at 0x0, cruise_airspeed at 0x4,
// sensor_enabled at 0x8.
module airspeed_complementary_filter_top import acf_pkg::*; #(
  parameter int DIGIT_W = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [17:0]        measured_airspeed,
  input  logic               airspeed_valid,
  input  logic [15:0]        density_ratio,
  input  logic signed [17:0] raw_speed_rate,
  input  logic [16:0]        time_step,
  input  logic               in_air,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [17:0]        tas_estimate,
  output logic signed [23:0] tas_rate_estimate,
  output logic signed [18:0] innovation
);

  cfg_t cfg;

  acf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  acf_core #(.DIGIT_W(DIGIT_W)) u_core (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .measured_airspeed (measured_airspeed),
    .airspeed_valid    (airspeed_valid),
    .density_ratio     (density_ratio),
    .raw_speed_rate    (raw_speed_rate),
    .time_step         (time_step),
    .in_air            (in_air),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .tas_estimate      (tas_estimate),
    .tas_rate_estimate (tas_rate_estimate),
    .innovation        (innovation)
  );

endmodule
